// ===== rtl/rs_pkg.sv =====
// ----------------------------------------------------------------------------
// rs_pkg: shared types and constants for the row softmax block
// Fixed-point constants for the exponential and the sequencer state type.
// ----------------------------------------------------------------------------
package rs_pkg;

  // Row buffer geometry.
  localparam int MAX_ROW = 64;
  localparam int ADDR_W  = $clog2(MAX_ROW);
  localparam int CNT_W   = ADDR_W + 1;

  // Score and probability formats.
  localparam int SCORE_W = 16;
  localparam int PROB_W  = 16;
  localparam int SUM_W   = 23;

  // Exponential: exp(-1/256) in Q0.32, the cutoff and the bits of the distance used.
  localparam logic [31:0] EXP_STEP   = 32'd4278222805;
  localparam logic [16:0] EXP_CUTOFF = 17'd4096;
  localparam int          EXP_BITS   = 13;
  localparam logic [15:0] EXP_SCALE  = 16'hFFFF;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Divider: dividend is 2^32, so the quotient has 33 bits.
  localparam int QUO_W = 33;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_EXPA,
    S_EXPF,
    S_EXPE,
    S_ACC,
    S_DIV,
    S_PMUL,
    S_OUT
  } rs_state_t;

endpackage

// ===== rtl/rs_ram.sv =====
// ----------------------------------------------------------------------------
// rs_ram: generic single-port-write, registered-read memory
// One write port and one read port; read data is registered and appears in the cycle after raddr.
// ----------------------------------------------------------------------------
module rs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/row_softmax.sv =====
// ----------------------------------------------------------------------------
// row_softmax: max-subtracted softmax over one row of Q8.8 scores
// Stores a row, then emits one Q0.16 probability per stored element.
// ----------------------------------------------------------------------------
//   Channel  Handshake       Payload
//   in       valid / stall   score, row_last
//   out      out_valid/out_stall  prob, last, overflow
//
// A score that does not close its row is taken with stall low. A closing
// score starts a sum pass and an output pass over the stored row, each with
// two shared-multiplier steps per exponent bit, and a bit-serial reciprocal
// division runs in between. The one 33x32 multiplier serves both passes.
// Input stall is high for the whole row computation; output stall holds the
// current result. Reset is synchronous and clears control.
module row_softmax (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         stall,
  input  logic signed [15:0]           score,
  input  logic                         row_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  prob,
  output logic                         last,
  output logic                         overflow
);
  import rs_pkg::*;

  rs_state_t state, state_next;

  logic signed [SCORE_W-1:0] row_max;
  logic [CNT_W-1:0]          elem_count;
  logic                      dropped_flag;
  logic [SUM_W-1:0]          exp_sum;
  logic [ADDR_W-1:0]         idx;
  logic                      out_pass;
  logic [16:0]               gap;
  logic [MUL_A_W-1:0]        acc;
  logic [31:0]               f;
  logic [3:0]                k;
  logic [15:0]               e;
  logic [23:0]               rem;
  logic [QUO_W-1:0]          recip;
  logic [5:0]                j;

  logic                      accept;
  logic                      store_ok;
  logic                      is_last_elem;
  logic signed [SCORE_W-1:0] rdata;
  logic [16:0]               gap_now;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         prod_rnd;
  logic [23:0]               rem_sh;
  logic                      rem_ge;

  assign accept       = valid && !stall;
  assign store_ok     = elem_count < CNT_W'(MAX_ROW);
  assign is_last_elem = ({1'b0, idx} + CNT_W'(1)) == elem_count;
  assign gap_now      = 17'({row_max[15], row_max} - {rdata[15], rdata});

  // Row buffer.
  rs_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_ROW)) u_store (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (elem_count[ADDR_W-1:0]),
    .wdata (score),
    .raddr (idx),
    .rdata (rdata)
  );

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = acc;
    mul_b = f;
    case (state)
      S_EXPF: begin
        mul_a = {1'b0, f};
        mul_b = f;
      end
      S_EXPE: begin
        mul_a = acc;
        mul_b = {16'd0, EXP_SCALE};
      end
      S_PMUL: begin
        mul_a = recip;
        mul_b = {16'd0, e};
      end
      default: begin
        mul_a = acc;
        mul_b = f;
      end
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_rnd = prod + (PROD_W'(1) << 31);

  // One restoring division step.
  assign rem_sh = {rem[22:0], (j == 6'd32)};
  assign rem_ge = rem_sh >= {1'b0, exp_sum};

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && row_last) state_next = S_RD;
      S_RD:   state_next = S_LD;
      S_LD: begin
        if (gap_now > EXP_CUTOFF) state_next = out_pass ? S_PMUL : S_ACC;
        else                      state_next = S_EXPA;
      end
      S_EXPA: state_next = S_EXPF;
      S_EXPF: state_next = (k == 4'(EXP_BITS - 1)) ? S_EXPE : S_EXPA;
      S_EXPE: state_next = out_pass ? S_PMUL : S_ACC;
      S_ACC:  state_next = is_last_elem ? S_DIV : S_RD;
      S_DIV:  if (j == 6'd0) state_next = S_RD;
      S_PMUL: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = is_last_elem ? S_IDLE : S_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    stall     = (state != S_IDLE);
    out_valid = (state == S_OUT);
    last      = is_last_elem;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_max      <= -16'sd32768;
      elem_count   <= '0;
      dropped_flag <= 1'b0;
      exp_sum      <= '0;
      idx          <= '0;
      out_pass     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_ok) begin
              elem_count <= elem_count + CNT_W'(1);
              if (score > row_max) row_max <= score;
            end else begin
              dropped_flag <= 1'b1;
            end
            if (row_last) begin
              exp_sum  <= '0;
              idx      <= '0;
              out_pass <= 1'b0;
            end
          end
        end
        S_ACC: begin
          exp_sum <= exp_sum + SUM_W'(e);
          if (!is_last_elem) idx <= idx + ADDR_W'(1);
        end
        S_DIV: begin
          if (j == 6'd0) begin
            out_pass <= 1'b1;
            idx      <= '0;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (is_last_elem) begin
              row_max      <= -16'sd32768;
              elem_count   <= '0;
              dropped_flag <= 1'b0;
            end else begin
              idx <= idx + ADDR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Arithmetic datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rem <= '0;
        j   <= 6'd32;
      end
      S_LD: begin
        gap <= gap_now;
        acc <= MUL_A_W'(1) << 32;
        f   <= EXP_STEP;
        k   <= '0;
        e   <= '0;
      end
      S_EXPA: if (gap[k]) acc <= prod_rnd[PROD_W-1 -: MUL_A_W];
      S_EXPF: begin
        f <= prod_rnd[63:32];
        k <= k + 4'd1;
      end
      S_EXPE: e <= prod_rnd[47:32];
      S_DIV: begin
        rem   <= rem_ge ? (rem_sh - {1'b0, exp_sum}) : rem_sh;
        recip <= {recip[QUO_W-2:0], rem_ge};
        j     <= j - 6'd1;
        if (j == 6'd0 && exp_sum == '0) recip <= '0;
      end
      S_PMUL: begin
        prob     <= (prod[PROD_W-1:32] != '0) ? 16'hFFFF : prod[31:16];
        overflow <= dropped_flag;
      end
      default: ;
    endcase
  end

endmodule
